// ===== hw/rtl/trw_pkg.sv =====
// Package for the TDC readout word reformatter.
// Holds word type codes, result kinds, register indexes, reset values and shared structs.
// Depends on nothing.
package trw_pkg;

  localparam logic [4:0] TYPE_DATA      = 5'h00;
  localparam logic [4:0] TYPE_CHIP_HEAD = 5'h01;
  localparam logic [4:0] TYPE_CHIP_TAIL = 5'h03;
  localparam logic [4:0] TYPE_ERROR     = 5'h04;
  localparam logic [4:0] TYPE_HEADER    = 5'h08;
  localparam logic [4:0] TYPE_TRAILER   = 5'h10;
  localparam logic [4:0] TYPE_TIMETAG   = 5'h11;
  localparam logic [4:0] TYPE_FILLER    = 5'h18;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_SLOT    = 2'd1;
  localparam logic [1:0] KIND_PATCHED = 2'd2;

  localparam logic [1:0] REG_OVERHEAD_WORDS = 2'd0;
  localparam logic [1:0] REG_WIDE_MASK      = 2'd1;
  localparam logic [1:0] REG_SLOT_FIX       = 2'd2;

  localparam logic [7:0]  OVERHEAD_RESET  = 8'd9;
  localparam logic [31:0] WIDE_MASK_RESET = 32'h0000_0000;
  localparam logic        SLOT_FIX_RESET  = 1'b1;

  typedef struct packed {
    logic [7:0]  overhead_words;
    logic [31:0] wide_format_slot_mask;
    logic        slot_fix_enable;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  current_slot;
    logic [13:0] counted_words;
    logic [13:0] overhead_count;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] word;
    logic        count_mismatch;
    logic        slot_replaced;
  } result_t;

endpackage

// ===== hw/rtl/trw_cfg_regs.sv =====
// Configuration registers of the TDC readout word reformatter.
// Uses trw_pkg for register indexes, reset values and the cfg_t struct.
module trw_cfg_regs
  import trw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OVERHEAD_WORDS: cfg_d.overhead_words = cfg_data_i[7:0];
        REG_WIDE_MASK:      cfg_d.wide_format_slot_mask = cfg_data_i;
        REG_SLOT_FIX:       cfg_d.slot_fix_enable = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overhead_words        <= OVERHEAD_RESET;
      cfg_q.wide_format_slot_mask <= WIDE_MASK_RESET;
      cfg_q.slot_fix_enable       <= SLOT_FIX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/trw_decode.sv =====
// Word decoder of the TDC readout word reformatter: from one readout word and
// the board state it forms the result and the next state. Uses trw_pkg.
module trw_decode
  import trw_pkg::*;
(
  input  logic [31:0] raw_word_i,
  input  logic [4:0]  expected_slot_i,
  input  cfg_t        cfg_i,
  input  state_t      state_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [4:0]  word_type;
  logic        wide;
  logic [6:0]  chan;
  logic [18:0] value;
  logic [4:0]  hdr_slot;
  logic        repl;
  logic [26:0] diff;

  assign word_type = raw_word_i[31:27];
  assign wide      = cfg_i.wide_format_slot_mask[state_i.current_slot];
  assign chan      = wide ? {2'b00, raw_word_i[25:21]} : raw_word_i[25:19];
  assign value     = wide ? raw_word_i[18:0] : {raw_word_i[16:0], 2'b00};
  assign repl      = cfg_i.slot_fix_enable && (raw_word_i[4:0] != expected_slot_i);
  assign hdr_slot  = repl ? expected_slot_i : raw_word_i[4:0];
  assign diff      = {13'd0, raw_word_i[18:5]} - {13'd0, state_i.overhead_count};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (word_type) inside
      TYPE_DATA: begin
        state_o.counted_words = state_i.counted_words + 14'd1;
        result_o.valid = 1'b1;
        result_o.kind  = KIND_DATA;
        result_o.word  = {state_i.current_slot, raw_word_i[26], chan, value};
      end
      TYPE_HEADER: begin
        state_o.current_slot   = hdr_slot;
        state_o.counted_words  = 14'd1;
        state_o.overhead_count = {6'd0, cfg_i.overhead_words};
        result_o.valid         = 1'b1;
        result_o.kind          = KIND_SLOT;
        result_o.word          = {27'd0, hdr_slot};
        result_o.slot_replaced = repl;
      end
      TYPE_TRAILER: begin
        result_o.valid          = 1'b1;
        result_o.kind           = KIND_PATCHED;
        result_o.word           = {diff, state_i.current_slot};
        result_o.count_mismatch = (diff != {13'd0, state_i.counted_words});
      end
      TYPE_TIMETAG, TYPE_ERROR: begin
        state_o.overhead_count = state_i.overhead_count + 14'd1;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tdc_readout_word_reformatter_top.sv =====
// Top level of the TDC readout word reformatter.
// Instantiates trw_cfg_regs and trw_decode; uses trw_pkg.
//
// Usage: readout words enter on the in channel (in_valid_i/in_ready_o) with
// the expected slot of the board being read. Each request is captured in an
// input register, decoded by one pass of short logic and, if it yields a
// result, placed in an output register shown on the out channel
// (out_valid_o/out_ready_i). Headers, data words and trailers give one
// result each; time tags and error words only bump the overhead count;
// other words give nothing.
// A result passes from the input register to the output register before it shows on
// out_valid_o, and one request is taken every cycle while the receiver does not stall.
// When the receiver stalls, the full output register holds and the input register
// keeps its request, so the in channel stalls after at most one further request;
// a word with no result waits there too.
// Reset clears the board state (slot, counters) and both pipeline valids and
// loads the configuration reset values. Configuration is written through
// cfg_we_i/cfg_index_i/cfg_data_i while the block is idle.
module tdc_readout_word_reformatter_top
  import trw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] raw_word_i,
  input  logic [4:0]  expected_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_word_o,
  output logic        count_mismatch_o,
  output logic        slot_replaced_o
);

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t result;

  logic        in_valid_q;
  logic [31:0] raw_word_q;
  logic [4:0]  expected_slot_q;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q;
  logic [31:0] out_word_q;
  logic        count_mismatch_q;
  logic        slot_replaced_q;
  logic        advance;

  trw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  trw_decode u_decode (
    .raw_word_i      (raw_word_q),
    .expected_slot_i (expected_slot_q),
    .cfg_i           (cfg),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (result)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = result.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_word_q      <= raw_word_i;
      expected_slot_q <= expected_slot_i;
    end
    if (advance && result.valid) begin
      out_kind_q       <= result.kind;
      out_word_q       <= result.word;
      count_mismatch_q <= result.count_mismatch;
      slot_replaced_q  <= result.slot_replaced;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_kind_q;
  assign out_word_o       = out_word_q;
  assign count_mismatch_o = count_mismatch_q;
  assign slot_replaced_o  = slot_replaced_q;

endmodule
